>>> rtl/priority_ordered_deque_top_defines.svh
// Assertion macros for the verification-side checker of the deque.
// No dependencies; included by pod_checker.sv.
`ifndef PRIORITY_ORDERED_DEQUE_TOP_DEFINES_SVH
`define PRIORITY_ORDERED_DEQUE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define POD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pod: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define POD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pod: next-cycle check failed");

`endif

>>> rtl/pod_pkg.sv
// Shared types and constants for the priority-ordered deque.
// No dependencies; imported by all RTL modules.
package pod_pkg;

  localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [2:0] OP_PUSH_PRIO  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_POP_FRONT  = 3'd4;
  localparam logic [2:0] OP_CLEAR      = 3'd5;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_EMPTY = 2'd2;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_TUSER_W = 3;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;  // latch the accepted request
    logic cmp;   // register key comparisons against every cell
    logic exec;  // commit the operation and load the result register
  } pod_cmd_t;

endpackage

>>> rtl/pod_ctrl.sv
// Controller FSM for the priority-ordered deque: sequences load, compare, execute.
// Depends on pod_pkg.
module pod_ctrl
  import pod_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output pod_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       oval_r, oval_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = oval_r;

  always_comb begin
    cmd.load  = in_tvalid && (state_r == ST_IDLE);
    cmd.cmp   = (state_r == ST_CMP);
    // result register must be free (or draining) before commit
    cmd.exec  = (state_r == ST_EXEC) && (!oval_r || out_tready);
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.load) state_nxt = ST_CMP;
      end
      ST_CMP: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (cmd.exec) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    oval_nxt = oval_r;
    if (oval_r && out_tready) oval_nxt = 1'b0;
    if (cmd.exec) oval_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      oval_r  <= oval_nxt;
    end
  end

endmodule

>>> rtl/pod_datapath.sv
// Datapath of the priority-ordered deque: shift-register cell chain, count,
// parallel key comparators and result register. Depends on pod_pkg.
module pod_datapath
  import pod_pkg::*;
#(
  parameter int DEPTH = 16
)
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  pod_cmd_t               cmd,
  input  logic [2:0]             in_opcode,
  input  logic signed [15:0]     in_key,
  input  logic [31:0]            in_payload,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [OUT_TUSER_W-1:0] out_tuser
);

  localparam int CW = $clog2(DEPTH + 1);

  // cells: position 0 is the head
  logic signed [15:0] key_r [DEPTH];
  logic signed [15:0] key_nxt [DEPTH];
  logic [31:0]        pay_r [DEPTH];
  logic [31:0]        pay_nxt [DEPTH];
  logic [CW-1:0]      cnt_r, cnt_nxt;

  logic [2:0]         op_r;
  logic signed [15:0] kreq_r;
  logic [31:0]        preq_r;
  logic [DEPTH-1:0]   gt_r;       // cell key > request key
  logic               head_ge_r;  // head key >= request key

  logic [OUT_TDATA_W-1:0] odata_r, odata_nxt;
  logic [OUT_TUSER_W-1:0] ouser_r, ouser_nxt;

  logic [DEPTH-1:0] vld, tail_oh, hit, mid, ge;
  logic             full, empty, tail_gt, pvalid;
  logic [1:0]       err;
  logic [15:0]      pkey, tkey;
  logic [31:0]      pdata, tdata;
  logic [4:0]       occ;

  // inclusive prefix OR, log-depth
  function automatic logic [DEPTH-1:0] prefix_or(input logic [DEPTH-1:0] v);
    logic [DEPTH-1:0] acc;
    acc = v;
    for (int s = 1; s < DEPTH; s = s * 2) begin
      acc = acc | (acc << s);
    end
    return acc;
  endfunction

  always_comb begin
    full  = (cnt_r == CW'(DEPTH));
    empty = (cnt_r == '0);
    tkey  = '0;
    tdata = '0;
    for (int i = 0; i < DEPTH; i++) begin
      vld[i]     = (CW'(i) < cnt_r);
      tail_oh[i] = (CW'(i + 1) == cnt_r);
      hit[i]     = (i != 0) && vld[i] && gt_r[i];
      tkey       = tkey  | ({16{tail_oh[i]}} & key_r[i]);
      tdata      = tdata | ({32{tail_oh[i]}} & pay_r[i]);
    end
    tail_gt = |(gt_r & tail_oh);
    mid     = prefix_or(hit);

    // ge[i]: cell i lies at or after the insert point
    case (op_r)
      OP_PUSH_FRONT: ge = '1;
      OP_PUSH_PRIO: begin
        if (empty || !tail_gt) ge = ~vld;
        else if (head_ge_r)    ge = '1;
        else                   ge = mid;
      end
      default: ge = ~vld;
    endcase

    key_nxt = key_r;
    pay_nxt = pay_r;
    cnt_nxt = cnt_r;
    pvalid  = 1'b0;
    pkey    = '0;
    pdata   = '0;
    err     = ERR_NONE;

    case (op_r)
      OP_PUSH_BACK, OP_PUSH_FRONT, OP_PUSH_PRIO: begin
        if (full) begin
          err = ERR_FULL;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (i != 0 && ge[(i == 0) ? 0 : i - 1]) begin
              key_nxt[i] = key_r[(i == 0) ? 0 : i - 1];
              pay_nxt[i] = pay_r[(i == 0) ? 0 : i - 1];
            end else if (ge[i]) begin
              key_nxt[i] = kreq_r;
              pay_nxt[i] = preq_r;
            end
          end
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          err = ERR_EMPTY;
        end else begin
          pvalid  = 1'b1;
          pkey    = tkey;
          pdata   = tdata;
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          err = ERR_EMPTY;
        end else begin
          pvalid = 1'b1;
          pkey   = key_r[0];
          pdata  = pay_r[0];
          for (int i = 0; i < DEPTH - 1; i++) begin
            key_nxt[i] = key_r[i + 1];
            pay_nxt[i] = pay_r[i + 1];
          end
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      OP_CLEAR: begin
        cnt_nxt = '0;
      end
      default: begin
      end
    endcase

    occ       = 5'(cnt_nxt);
    odata_nxt = {2'b00, (cnt_nxt == '0), occ, pdata, pkey};
    ouser_nxt = {err, pvalid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.exec) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_opcode;
      kreq_r <= in_key;
      preq_r <= in_payload;
    end
    if (cmd.cmp) begin
      for (int i = 0; i < DEPTH; i++) begin
        gt_r[i] <= (key_r[i] > kreq_r);
      end
      head_ge_r <= (key_r[0] >= kreq_r);
    end
    if (cmd.exec) begin
      key_r   <= key_nxt;
      pay_r   <= pay_nxt;
      odata_r <= odata_nxt;
      ouser_r <= ouser_nxt;
    end
  end

  assign out_tdata = odata_r;
  assign out_tuser = ouser_r;

endmodule

>>> rtl/priority_ordered_deque_top.sv
// Top level of the priority-ordered deque: controller plus datapath.
// Depends on pod_pkg, pod_ctrl, pod_datapath.
//
//  channel | dir | ports                        | contents
//  --------+-----+------------------------------+------------------------------
//  in      | in  | in_tvalid/tready/tdata/tuser | one deque operation
//  out     | out | out_tvalid/tready/tdata/tuser| one result per operation
//
// Sequence: each operation is accepted, compared and executed, as set by the
// controller's load/compare/commit sequence; all cell keys are compared in
// parallel in the compare cycle. The result sits in an output register.
// Reset: synchronous, active-low rst_n; empties the deque and drops any result.
// Stalls: if the previous result has not been taken, execute waits for it.
module priority_ordered_deque_top
  import pod_pkg::*;
#(
  parameter int DEPTH = 16
)
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // in_tdata, low to high: priority_req[15:0], payload[47:16]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: opcode[2:0]
  input  logic [2:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_tdata, low to high: popped_priority[15:0], popped_payload[47:16],
  // occupancy[52:48], is_empty[53], zero fill[55:54]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // out_tuser, low to high: popped_valid[0], error_code[2:1]
  output logic [OUT_TUSER_W-1:0] out_tuser
);

  pod_cmd_t cmd;

  pod_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  pod_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_opcode  (in_tuser),
    .in_key     (in_tdata[15:0]),
    .in_payload (in_tdata[47:16]),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

>>> rtl/pod_checker.sv
// Port-level checker for the priority-ordered deque, bound to the top level.
// Depends on priority_ordered_deque_top_defines.svh and pod_pkg.
`include "priority_ordered_deque_top_defines.svh"

module pod_checker
  import pod_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [OUT_TUSER_W-1:0] out_tuser
);

  // stalled result holds
  `POD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // empty flag agrees with a zero occupancy
  `POD_ASSERT_IMPL(a_empty_occ, clk, rst_n, out_tvalid && out_tdata[53], out_tdata[52:48] == 5'd0)

  // a removed entry never comes with an error
  `POD_ASSERT_IMPL(a_pop_ok, clk, rst_n, out_tvalid && out_tuser[0], out_tuser[2:1] == ERR_NONE)

  // no removed entry: key and payload read as zero
  `POD_ASSERT_IMPL(a_zero_fill, clk, rst_n, out_tvalid && !out_tuser[0], out_tdata[47:0] == 48'd0)

endmodule

bind priority_ordered_deque_top pod_checker u_pod_checker (.*);

>>> bench/pod_deque_tracker.sv
// Tracks the priority-ordered deque: mirrors its contents from the accepted
// operations and checks every result transfer. Depends on pod_pkg.
module pod_deque_tracker
  import pod_pkg::*;
#(
  parameter int DEPTH = 16
)
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  // in_tdata, low to high: priority_req[15:0], payload[47:16]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: opcode[2:0]
  input  logic [2:0]             in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // out_tdata, low to high: popped_priority[15:0], popped_payload[47:16],
  // occupancy[52:48], is_empty[53]
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  // out_tuser, low to high: popped_valid[0], error_code[2:1]
  input  logic [OUT_TUSER_W-1:0] out_tuser,
  output int unsigned            mismatch_count,
  output int unsigned            pending_results,
  output int unsigned            results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        valid;
    logic [15:0] key;
    logic [31:0] data;
    logic [1:0]  err;
    logic [4:0]  occ;
    logic        empty;
  } pod_result_t;

  // Mirror of the deque, head at index 0.
  logic signed [15:0] held_keys [DEPTH];
  logic [31:0]        held_data [DEPTH];
  int                 held_count = 0;

  pod_result_t awaited_results [$];
  int unsigned errs    = 0;
  int unsigned checked = 0;

  // Tail if empty or key >= tail, head if key <= head, else before the first
  // later entry with a greater key.
  function automatic int prio_slot(input logic signed [15:0] key);
    if (held_count == 0 || key >= held_keys[held_count-1]) return held_count;
    if (key <= held_keys[0]) return 0;
    for (int j = 1; j < held_count; j++) begin
      if (held_keys[j] > key) return j;
    end
    return held_count;
  endfunction

  function automatic pod_result_t apply_op(input logic [2:0] op,
                                           input logic signed [15:0] key,
                                           input logic [31:0] data);
    pod_result_t r;
    int slot;
    r = '0;
    r.err = ERR_NONE;
    case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT, OP_PUSH_PRIO: begin
        if (held_count >= DEPTH) begin
          r.err = ERR_FULL;
        end else begin
          if (op == OP_PUSH_BACK) slot = held_count;
          else if (op == OP_PUSH_FRONT) slot = 0;
          else slot = prio_slot(key);
          for (int i = held_count; i > slot; i--) begin
            held_keys[i] = held_keys[i-1];
            held_data[i] = held_data[i-1];
          end
          held_keys[slot] = key;
          held_data[slot] = data;
          held_count++;
        end
      end
      OP_POP_BACK, OP_POP_FRONT: begin
        if (held_count == 0) begin
          r.err = ERR_EMPTY;
        end else begin
          slot = (op == OP_POP_BACK) ? held_count - 1 : 0;
          r.valid = 1'b1;
          r.key   = held_keys[slot];
          r.data  = held_data[slot];
          for (int i = slot; i < held_count - 1; i++) begin
            held_keys[i] = held_keys[i+1];
            held_data[i] = held_data[i+1];
          end
          held_count--;
        end
      end
      OP_CLEAR: held_count = 0;
      default: ;  // unused codes leave the deque alone
    endcase
    r.occ   = 5'(held_count);
    r.empty = (held_count == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    pod_result_t want;
    pod_result_t got;
    if (!rst_n) begin
      held_count = 0;
      awaited_results.delete();
    end else begin
      if (in_tvalid && in_tready)
        awaited_results.push_back(apply_op(in_tuser, in_tdata[15:0], in_tdata[47:16]));
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with no operation outstanding");
          errs++;
        end else begin
          want      = awaited_results.pop_front();
          got.valid = out_tuser[0];
          got.err   = out_tuser[2:1];
          got.key   = out_tdata[15:0];
          got.data  = out_tdata[47:16];
          got.occ   = out_tdata[52:48];
          got.empty = out_tdata[53];
          checked++;
          if (got.valid !== want.valid) begin
            $error("popped_valid: expected %0d, got %0d", want.valid, got.valid);
            errs++;
          end
          if (got.key !== want.key) begin
            $error("popped_priority: expected %0d, got %0d",
                   $signed(want.key), $signed(got.key));
            errs++;
          end
          if (got.data !== want.data) begin
            $error("popped_payload: expected %h, got %h", want.data, got.data);
            errs++;
          end
          if (got.err !== want.err) begin
            $error("error_code: expected %0d, got %0d", want.err, got.err);
            errs++;
          end
          if (got.occ !== want.occ) begin
            $error("occupancy: expected %0d, got %0d", want.occ, got.occ);
            errs++;
          end
          if (got.empty !== want.empty) begin
            $error("is_empty: expected %0d, got %0d", want.empty, got.empty);
            errs++;
          end
        end
      end
    end
    mismatch_count  <= errs;
    pending_results <= awaited_results.size();
    results_checked <= checked;
  end

endmodule

>>> bench/tb_priority_ordered_deque_top.sv
// Top of the deque bench: clock, reset, operation stimulus and result-side
// backpressure. Depends on pod_pkg, priority_ordered_deque_top, pod_deque_tracker.
module tb_priority_ordered_deque_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pod_pkg::*;

  localparam int DEQUE_DEPTH = 16;
  // Codes 6 and 7 are not operations; the block must report a no-op.
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam int RANDOM_OPS       = 450;
  localparam int PHASE_OPS        = 30;
  localparam int QUIET_TAIL_OPS   = 60;    // last stretch runs with no idling
  localparam int LONG_HOLD_CYCLES = 150;
  localparam int DRAIN_CYCLES     = 20;    // margin after the last result is taken
  // Slowest run: ~480 ops, each with the longest idle gap, stall burst and block sequence, plus the long hold.
  localparam int CYCLE_LIMIT      = 200000;

  // Phase kinds of the random part.
  localparam int PH_FILL  = 0;
  localparam int PH_MIXED = 1;
  localparam int PH_DRAIN = 2;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [2:0]             in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  int unsigned mismatch_count;
  int unsigned pending_results;
  int unsigned results_checked;

  // Knobs shared between the sender and the receiver process.
  bit src_idle_en   = 1'b0;
  bit sink_idle_en  = 1'b0;
  bit long_hold_req = 1'b0;

  int unsigned cycle_count = 0;
  int unsigned n_push      = 0;
  int unsigned n_pop       = 0;
  int unsigned n_other     = 0;

  priority_ordered_deque_top #(.DEPTH(DEQUE_DEPTH)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  pod_deque_tracker #(.DEPTH(DEQUE_DEPTH)) u_tracker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results),
    .results_checked (results_checked)
  );

  always #2 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("watchdog expired after %0d cycles, %0d results outstanding",
             cycle_count, pending_results);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Keys: a mix of full-range, tight clusters (lots of ties) and extremes.
  function automatic logic [15:0] pick_key();
    int k;
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: begin
        k = $urandom_range(0, 8);
        return 16'(k - 4);
      end
      2: begin
        case ($urandom_range(0, 5))
          0: return 16'h8000;
          1: return 16'h8001;
          2: return 16'hFFFF;
          3: return 16'h0000;
          4: return 16'h7FFE;
          default: return 16'h7FFF;
        endcase
      end
      default: begin
        k = $urandom_range(0, 400);
        return 16'(k - 200);
      end
    endcase
  endfunction

  // Operation mix by phase; fill phases push the deque into its full state,
  // drain phases into its empty state.
  function automatic logic [2:0] pick_op(input int phase_kind);
    int r;
    int push_pct;
    r = $urandom_range(0, 99);
    push_pct = (phase_kind == PH_FILL) ? 85 : (phase_kind == PH_DRAIN) ? 20 : 50;
    if (r < push_pct) begin
      case ($urandom_range(0, 3))
        0:       return OP_PUSH_BACK;
        1:       return OP_PUSH_FRONT;
        default: return OP_PUSH_PRIO;  // priority insert gets half of the weight
      endcase
    end
    if (r < 96) return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
    if (r < 98) return OP_CLEAR;
    return $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
  endfunction

  // One operation transfer. Fields are set on the falling edge; the transfer
  // completes at the first rising edge that sees in_tready high. valid stays
  // high back to back unless an idle burst is inserted.
  task automatic issue_op(input logic [2:0] op, input logic [15:0] key,
                          input logic [31:0] data);
    int gap;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {data, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT, OP_PUSH_PRIO: n_push++;
      OP_POP_BACK, OP_POP_FRONT:                 n_pop++;
      default:                                   n_other++;
    endcase
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request so the
  // block backs up and drops in_tready while the sender keeps offering.
  initial begin
    int burst;
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        out_tready <= 1'b1;
      end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 12);
        out_tready <= 1'b0;
        repeat (burst - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Stimulus: directed corner cases, then phased random traffic.
  initial begin
    int counted;
    int phase;
    int phase_kind;
    int in_phase;
    logic [2:0] op;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty-deque refusals, clear on empty, unused code with
    // non-zero fields, every priority placement (tail, head, middle, tie),
    // key/payload extremes, both pops, fill to full and a refused push.
    issue_op(OP_POP_BACK,  16'h0000, 32'h0000_0000);
    issue_op(OP_POP_FRONT, 16'h0000, 32'h0000_0000);
    issue_op(OP_CLEAR,     16'h0000, 32'h0000_0000);
    issue_op(OP_SPARE_6,   16'hFFFF, 32'hFFFF_FFFF);
    issue_op(OP_PUSH_PRIO, 16'h0000, 32'h0000_0001);  // empty -> tail
    issue_op(OP_PUSH_PRIO, 16'h7FFF, 32'h0000_0002);  // >= tail -> tail
    issue_op(OP_PUSH_PRIO, 16'h8000, 32'h0000_0003);  // <= head -> head
    issue_op(OP_PUSH_PRIO, 16'd100,  32'h0000_0004);  // middle
    issue_op(OP_PUSH_PRIO, 16'd100,  32'h0000_0005);  // tie goes after equal key
    issue_op(OP_PUSH_BACK, 16'hFFFF, 32'hFFFF_FFFF);
    issue_op(OP_PUSH_FRONT, 16'd5,   32'h0000_0000);
    issue_op(OP_POP_FRONT, 16'h0000, 32'h0000_0000);
    issue_op(OP_POP_BACK,  16'h0000, 32'h0000_0000);
    repeat (11) issue_op(OP_PUSH_PRIO, pick_key(), $urandom);  // now 16 held
    issue_op(OP_PUSH_FRONT, 16'h1234, 32'hA5A5_5A5A);          // refused, full
    issue_op(OP_CLEAR,     16'h0000, 32'h0000_0000);

    // Random part in phases; spare codes do not count toward the total.
    counted = 0;
    phase   = 0;
    while (counted < RANDOM_OPS) begin
      phase_kind = phase % 3;
      if (counted >= RANDOM_OPS - QUIET_TAIL_OPS) begin
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
      end else if (phase == 4) begin
        // Backpressure phase: sender runs gap-free into a long receiver hold.
        src_idle_en   = 1'b0;
        sink_idle_en  = 1'b0;
        long_hold_req = 1'b1;
      end else begin
        src_idle_en  = ($urandom_range(0, 2) != 0);
        sink_idle_en = ($urandom_range(0, 2) != 0);
      end
      in_phase = 0;
      while (in_phase < PHASE_OPS && counted < RANDOM_OPS) begin
        op = pick_op(phase_kind);
        issue_op(op, pick_key(), $urandom);
        if (op != OP_SPARE_6 && op != OP_SPARE_7) begin
          counted++;
          in_phase++;
        end
      end
      phase++;
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d pushes, %0d pops, %0d clears/unused codes in %0d phases;",
             n_push, n_pop, n_other, phase);
    $display("%0d results checked, long receiver hold-off exercised, %0d cycles.",
             results_checked, cycle_count);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
